@@ sv/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Field widths, byte class patterns and the replacement code point.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 2;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [CpW-1:0]    cp_t;
  typedef logic [CountW-1:0] count_t;

  localparam cp_t REPLACEMENT_CP = cp_t'(21'h00FFFD);

  localparam byte_t ASCII_MASK = 8'h80;
  localparam byte_t LEAD2_MASK = 8'hE0;
  localparam byte_t LEAD2_PAT  = 8'hC0;
  localparam byte_t LEAD3_MASK = 8'hF0;
  localparam byte_t LEAD3_PAT  = 8'hE0;
  localparam byte_t LEAD4_MASK = 8'hF8;
  localparam byte_t LEAD4_PAT  = 8'hF0;
  localparam byte_t CONT_MASK  = 8'hC0;
  localparam byte_t CONT_PAT   = 8'h80;
  localparam byte_t CONT_BITS  = 8'h3F;
  localparam byte_t LEAD2_BITS = 8'h1F;
  localparam byte_t LEAD3_BITS = 8'h0F;
  localparam byte_t LEAD4_BITS = 8'h07;

endpackage

@@ sv/utf8d_if.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for text bytes and decoded code points.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic                 valid;
  logic                 ready;
  utf8d_pkg::byte_t     text_byte;
  logic                 end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8d_cp_if;
  logic                 valid;
  logic                 ready;
  utf8d_pkg::cp_t       code_point;
  logic                 replaced;
  logic                 final_result;

  modport source (output valid, output code_point, output replaced, output final_result,
                  input ready);
  modport sink   (input valid, input code_point, input replaced, input final_result,
                  output ready);
endinterface

@@ sv/utf8_byte_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder
// A byte request passes the input register, then the result register, before its
// code point request, if any, appears. The block takes one byte per cycle unless a
// held code point request stalls it, set by the single decode step between the two
// registers. Reset (rst, synchronous) empties both registers and clears the sequence state.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_core (
  input  logic            clk,
  input  logic            rst,
  utf8d_byte_if.sink      text,
  utf8d_cp_if.source      chars
);

  logic                s1_valid;
  utf8d_pkg::byte_t    s1_byte;
  logic                s1_eot;

  utf8d_pkg::count_t   expected;
  utf8d_pkg::cp_t      partial;

  logic                out_valid;
  utf8d_pkg::cp_t      out_cp;
  logic                out_repl;
  logic                out_fin;

  logic                advance;

  utf8d_pkg::count_t   expected_next;
  utf8d_pkg::cp_t      partial_next;
  logic                emit;
  utf8d_pkg::cp_t      cp_c;
  logic                repl_c;
  logic                fin_c;
  utf8d_pkg::cp_t      shifted;

  assign advance    = !out_valid || chars.ready;
  assign text.ready = !s1_valid || advance;

  assign chars.valid        = out_valid;
  assign chars.code_point   = out_cp;
  assign chars.replaced     = out_repl;
  assign chars.final_result = out_fin;

  assign shifted = {partial[utf8d_pkg::CpW-7:0], s1_byte[5:0]};

  always_comb begin
    expected_next = expected;
    partial_next  = partial;
    emit          = 1'b0;
    cp_c          = utf8d_pkg::REPLACEMENT_CP;
    repl_c        = 1'b1;
    fin_c         = s1_eot;
    if (expected == '0) begin
      priority if ((s1_byte & utf8d_pkg::ASCII_MASK) == '0) begin
        emit   = 1'b1;
        cp_c   = utf8d_pkg::cp_t'(s1_byte);
        repl_c = 1'b0;
      end else if ((s1_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
        expected_next = 2'd1;
        partial_next  = utf8d_pkg::cp_t'(s1_byte & utf8d_pkg::LEAD2_BITS);
      end else if ((s1_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
        expected_next = 2'd2;
        partial_next  = utf8d_pkg::cp_t'(s1_byte & utf8d_pkg::LEAD3_BITS);
      end else if ((s1_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT) begin
        expected_next = 2'd3;
        partial_next  = utf8d_pkg::cp_t'(s1_byte & utf8d_pkg::LEAD4_BITS);
      end else begin
        emit = 1'b1;
      end
    end else if ((s1_byte & utf8d_pkg::CONT_MASK) != utf8d_pkg::CONT_PAT) begin
      // drop the sequence, consume the byte
      expected_next = '0;
      partial_next  = '0;
      emit          = 1'b1;
    end else begin
      expected_next = expected - 2'd1;
      partial_next  = shifted;
      if (expected == 2'd1) begin
        emit         = 1'b1;
        cp_c         = shifted;
        repl_c       = 1'b0;
        partial_next = '0;
      end
    end
    if (s1_eot) begin
      if (expected_next != '0) begin
        emit   = 1'b1;
        cp_c   = utf8d_pkg::REPLACEMENT_CP;
        repl_c = 1'b1;
        fin_c  = 1'b1;
      end
      expected_next = '0;
      partial_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      expected  <= '0;
      partial   <= '0;
    end else begin
      if (text.ready) begin
        s1_valid <= text.valid;
      end
      if (advance) begin
        out_valid <= s1_valid && emit;
        if (s1_valid) begin
          expected <= expected_next;
          partial  <= partial_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready) begin
      s1_byte <= text.text_byte;
      s1_eot  <= text.end_of_text;
    end
    if (advance) begin
      out_cp   <= cp_c;
      out_repl <= repl_c;
      out_fin  <= fin_c;
    end
  end

endmodule

@@ bench/tb_utf8_byte_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder testbench
// Feeds a short table of directed bytes, then random one- to four-byte
// sequences mixed with truncated sequences, stray bytes and text ends. Both
// channels idle at random, and the code point side holds off once for a long
// stretch. Every code point request is checked in order against a
// cycle-free decode of the accepted bytes, or against the typed value of a
// table row.
// ----------------------------------------------------------------------------
module tb_utf8_byte_stream_decoder_core;

  localparam int NumRows     = 25;
  localparam int RandomBytes = 1300;
  localparam int IdleLimit   = 2000;
  localparam int LongHold    = 400;

  typedef struct packed {
    utf8d_pkg::cp_t code_point;
    logic           replaced;
    logic           final_result;
  } char_t;

  typedef struct packed {
    utf8d_pkg::byte_t b;
    logic             eot;
    logic             typed;
    utf8d_pkg::cp_t   cp;
    logic             repl;
    logic             fin;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  utf8d_byte_if text_bus ();
  utf8d_cp_if   chars_bus ();

  utf8_byte_stream_decoder_core dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_bus),
    .chars (chars_bus)
  );

  always #10 clk = ~clk;

  char_t             expected_chars[$];
  utf8d_pkg::count_t conts_left = '0;
  utf8d_pkg::cp_t    partial_cp = '0;
  int     errors     = 0;
  int     bytes_sent = 0;
  int     chars_seen = 0;
  int     idle_cycles = 0;
  bit     tx_steady  = 1'b0;

  row_t script [NumRows] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000,                1'b0, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 21'h00007F,                1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b1, utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b0},
    '{8'hFF, 1'b0, 1'b1, utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b0},
    '{8'hC2, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hA9, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hEF, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hBD, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hF7, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hBF, 1'b0, 1'b1, 21'h1FFFFF,                1'b0, 1'b0},
    '{8'hC0, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hE2, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'h41, 1'b0, 1'b1, utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b0},
    '{8'h41, 1'b0, 1'b1, 21'h000041,                1'b0, 1'b0},
    '{8'hF0, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'h9F, 1'b1, 1'b1, utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1},
    '{8'h41, 1'b1, 1'b1, 21'h000041,                1'b0, 1'b1},
    '{8'hC3, 1'b1, 1'b1, utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1},
    '{8'hE0, 1'b0, 1'b0, '0,                        1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1},
    '{8'hBF, 1'b1, 1'b1, utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1}
  };

  function automatic bit decode_byte(input utf8d_pkg::byte_t b, input logic eot,
                                     output char_t res);
    bit emit;
    emit = 1'b0;
    res  = '0;
    if (conts_left == 0) begin
      if ((b & utf8d_pkg::ASCII_MASK) == 0) begin
        res  = '{utf8d_pkg::cp_t'(b), 1'b0, eot};
        emit = 1'b1;
      end else if ((b & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
        conts_left = 2'd1;
        partial_cp = utf8d_pkg::cp_t'(b & utf8d_pkg::LEAD2_BITS);
      end else if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
        conts_left = 2'd2;
        partial_cp = utf8d_pkg::cp_t'(b & utf8d_pkg::LEAD3_BITS);
      end else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT) begin
        conts_left = 2'd3;
        partial_cp = utf8d_pkg::cp_t'(b & utf8d_pkg::LEAD4_BITS);
      end else begin
        res  = '{utf8d_pkg::REPLACEMENT_CP, 1'b1, eot};
        emit = 1'b1;
      end
    end else if ((b & utf8d_pkg::CONT_MASK) != utf8d_pkg::CONT_PAT) begin
      conts_left = '0;
      partial_cp = '0;
      res  = '{utf8d_pkg::REPLACEMENT_CP, 1'b1, eot};
      emit = 1'b1;
    end else begin
      partial_cp = (partial_cp << 6) | utf8d_pkg::cp_t'(b & utf8d_pkg::CONT_BITS);
      conts_left = conts_left - 2'd1;
      if (conts_left == 0) begin
        res  = '{partial_cp, 1'b0, eot};
        emit = 1'b1;
        partial_cp = '0;
      end
    end
    if (eot) begin
      if (conts_left != 0) begin
        res  = '{utf8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1};
        emit = 1'b1;
      end
      conts_left = '0;
      partial_cp = '0;
    end
    return emit;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endfunction

  task automatic send_byte(input utf8d_pkg::byte_t b, input logic eot, input logic typed,
                           input char_t typed_char);
    int    gap;
    bit    produced;
    char_t res;
    if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      text_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_bus.valid       <= 1'b1;
    text_bus.text_byte   <= b;
    text_bus.end_of_text <= eot;
    do @(posedge clk); while (!text_bus.ready);
    produced = decode_byte(b, eot, res);
    if (typed) expected_chars.push_back(typed_char);
    else if (produced) expected_chars.push_back(res);
    bytes_sent++;
  endtask

  task automatic send_random_run();
    utf8d_pkg::byte_t seq[$];
    int    kind;
    int    len;
    int    eot_at;
    kind   = $urandom_range(0, 9);
    len    = $urandom_range(2, 4);
    eot_at = -1;
    if (kind <= 2) begin
      seq.push_back(utf8d_pkg::byte_t'($urandom_range(0, 127)));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 4)) seq.push_back(utf8d_pkg::byte_t'($urandom_range(0, 255)));
    end else begin
      unique case (len)
        2: seq.push_back(utf8d_pkg::LEAD2_PAT |
                         (utf8d_pkg::byte_t'($urandom) & utf8d_pkg::LEAD2_BITS));
        3: seq.push_back(utf8d_pkg::LEAD3_PAT |
                         (utf8d_pkg::byte_t'($urandom) & utf8d_pkg::LEAD3_BITS));
        default: seq.push_back(utf8d_pkg::LEAD4_PAT |
                               (utf8d_pkg::byte_t'($urandom) & utf8d_pkg::LEAD4_BITS));
      endcase
      repeat (len - 1) seq.push_back(utf8d_pkg::CONT_PAT |
                                     (utf8d_pkg::byte_t'($urandom) & utf8d_pkg::CONT_BITS));
      if (kind == 7) repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
      if (kind == 9) eot_at = $urandom_range(0, seq.size() - 1);
    end
    if (eot_at < 0 && $urandom_range(0, 11) == 0) eot_at = seq.size() - 1;
    foreach (seq[i]) send_byte(seq[i], i == eot_at, 1'b0, '0);
  endtask

  task automatic check_char(input char_t got);
    char_t want;
    chars_seen++;
    if (expected_chars.size() == 0) begin
      errors++;
      $display("%0t ns: code point expected none, got 0x%0h (replaced %0b, final %0b)",
               $time, got.code_point, got.replaced, got.final_result);
    end else begin
      want = expected_chars.pop_front();
      compare_field("code_point", 32'(want.code_point), 32'(got.code_point));
      compare_field("replaced", 32'(want.replaced), 32'(got.replaced));
      compare_field("final_result", 32'(want.final_result), 32'(got.final_result));
    end
  endtask

  always @(posedge clk) begin
    if (rst || (text_bus.valid && text_bus.ready) || (chars_bus.valid && chars_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("utf8_byte_stream_decoder_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : drain
    int    gap;
    bit    long_hold_done;
    bit    rx_steady;
    char_t got;
    long_hold_done = 1'b0;
    rx_steady      = 1'b0;
    chars_bus.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 11);
      if (!long_hold_done && chars_seen >= 300) begin
        gap = LongHold;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        chars_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      chars_bus.ready <= 1'b1;
      do @(posedge clk); while (!chars_bus.valid);
      got = '{chars_bus.code_point, chars_bus.replaced, chars_bus.final_result};
      check_char(got);
    end
  end

  initial begin : stimulus
    text_bus.valid       <= 1'b0;
    text_bus.text_byte   <= '0;
    text_bus.end_of_text <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i])
      send_byte(script[i].b, script[i].eot, script[i].typed,
                '{script[i].cp, script[i].repl, script[i].fin});
    while (bytes_sent < NumRows + RandomBytes) send_random_run();
    text_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_byte_stream_decoder_core: match");
    end else begin
      $display("utf8_byte_stream_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

@@ utf8_byte_stream_decoder_core.f @@
sv/utf8d_pkg.sv
sv/utf8d_if.sv
sv/utf8_byte_stream_decoder_core.sv
bench/tb_utf8_byte_stream_decoder_core.sv
